// File: hw/rtl/tgar_pkg.sv
// Package for the TGA run-length pixel decoder.
// Register indexes, configuration and result structs, reset values and widths.
// No dependencies; used by every file under hw/rtl.
`default_nettype none

package tgar_pkg;

    // Default width of the pixel counter (image holds up to 2^N pixels)
    localparam int DEF_PIXEL_COUNT_BITS = 24;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int TOTAL_W     = 25;
    localparam int KEY_W       = 32;
    localparam int PIX_W       = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Pixel byte counts, as last byte index inside one pixel
    localparam logic [1:0] LAST_IDX_BGRA = 2'd3;
    localparam logic [1:0] LAST_IDX_BGR  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COMPRESSED  = 3'd0,
        CFG_FOUR_BPP    = 3'd1,
        CFG_PIXEL_TOTAL = 3'd2,
        CFG_USE_KEY     = 3'd3,
        CFG_COLOR_KEY   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               compressed;
        logic               four_bpp;
        logic [TOTAL_W-1:0] pixel_total;
        logic               use_key;
        logic [KEY_W-1:0]   color_key;
    } cfg_t;

    // Configuration after reset
    localparam cfg_t CFG_RESET = '{
        compressed:  1'b1,
        four_bpp:    1'b1,
        pixel_total: 25'd1,
        use_key:     1'b0,
        color_key:   32'hff00_0000
    };

    // One decoded pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       last_pixel;
        logic       overrun_error;
        logic       key_seen;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/tga_rle_pixel_decoder_core.sv
// Channel     | Dir | Signals                         | Contents
// ------------+-----+---------------------------------+---------------------------------------
// s_axis      | in  | tvalid tready tdata[7:0]        | data_byte
// m_axis      | out | tvalid tready tdata[39:0] tlast | pixel, repeat count; tlast=last_pixel
//             |     | tuser[1:0]                      | overrun_error, key_seen
// cfg         | in  | valid ready addr[2:0] data[31:0]| register write, always ready
//
// One byte per cycle while the result is not stalled; the byte that completes a result
// passes through the input register, then the decode logic into the result register,
// before that result can transfer.
// Reset (rst_n low) restores register defaults and expects a packet header first.
// A stalled result stalls the input register; one more byte is still taken behind it.
// Top level; depends on tgar_pkg, tgar_cfg, tgar_decode, tgar_out_reg.
`default_nettype none

module tga_rle_pixel_decoder_core #(
    parameter int PIXEL_COUNT_BITS = tgar_pkg::DEF_PIXEL_COUNT_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // tdata: [7:0] data_byte
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tgar_pkg::BYTE_W-1:0]      s_axis_tdata,
    // tdata: [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha, [39:32] repeat_res
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [tgar_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    // tuser: [0] overrun_error, [1] key_seen
    output logic [tgar_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tgar_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [tgar_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgar_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_xfer;
    logic              advance;
    logic              res_valid;
    res_t              res_comb;
    logic              out_valid;
    res_t              out_res;

    assign cfg_ready = 1'b1;

    tgar_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    // Input register: decode moves on when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    tgar_decode #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .data_byte (in_data_reg),
        .res_valid (res_valid),
        .res       (res_comb)
    );

    tgar_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .load_res (res_comb),
        .take     (m_axis_tready),
        .valid    (out_valid),
        .res      (out_res)
    );

    // Output packing
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_res.repeat_res, out_res.alpha, out_res.red,
                            out_res.green, out_res.blue};
    assign m_axis_tlast  = out_res.last_pixel;
    assign m_axis_tuser  = {out_res.key_seen, out_res.overrun_error};

endmodule

`default_nettype wire

// File: hw/rtl/tgar_cfg.sv
// Configuration register file of the TGA run-length pixel decoder.
// Depends on tgar_pkg (register indexes, cfg_t, reset values).
`default_nettype none

module tgar_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [tgar_pkg::CFG_ADDR_W-1:0] wr_addr,
    input  wire logic [tgar_pkg::CFG_DATA_W-1:0] wr_data,
    output tgar_pkg::cfg_t                       cfg
);
    import tgar_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; indexes beyond the list are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_addr))
                CFG_COMPRESSED:  cfg_next.compressed  = wr_data[0];
                CFG_FOUR_BPP:    cfg_next.four_bpp    = wr_data[0];
                CFG_PIXEL_TOTAL: cfg_next.pixel_total = wr_data[TOTAL_W-1:0];
                CFG_USE_KEY:     cfg_next.use_key     = wr_data[0];
                CFG_COLOR_KEY:   cfg_next.color_key   = wr_data[KEY_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tgar_decode.sv
// Packet and pixel decode state of the TGA run-length pixel decoder.
// One stream byte per step; packet header, pixel assembly, counts, flags.
// Depends on tgar_pkg (cfg_t, res_t, constants).
`default_nettype none

module tgar_decode #(
    parameter int PIXEL_COUNT_BITS = tgar_pkg::DEF_PIXEL_COUNT_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tgar_pkg::cfg_t             cfg,
    input  wire logic                       step,
    input  wire logic [tgar_pkg::BYTE_W-1:0] data_byte,
    output logic                            res_valid,
    output tgar_pkg::res_t                  res
);
    import tgar_pkg::*;

    // Pixel counter holds 0..2^N; compare width also covers pixel_total
    localparam int CW = PIXEL_COUNT_BITS + 1;
    localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;

    logic             expect_hdr_reg, expect_hdr_next;
    logic             run_reg,        run_next;
    logic [7:0]       remaining_reg,  remaining_next;
    logic [1:0]       bip_reg,        bip_next;
    logic [PIX_W-1:0] pix_reg,        pix_next;
    logic [CW-1:0]    done_reg,       done_next;
    logic             key_reg,        key_next;
    logic             ovr_reg,        ovr_next;

    logic [TW-1:0] total_ext;
    logic [TW-1:0] cap_ext;
    logic [TW-1:0] eff_ext;
    logic [CW-1:0] eff;
    logic [CW-1:0] left;
    logic          done_below;

    logic [1:0]    last_idx;
    logic [7:0]    hdr_count;
    logic [7:0]    rep_pre;
    logic [7:0]    rep;
    logic [CW-1:0] done_sum;
    logic          key_match;
    logic          is_last;

    // Effective image size: zero counts as one, clamp to 2^N
    always_comb
    begin
        total_ext = TW'(cfg.pixel_total);
        cap_ext   = TW'(1) << PIXEL_COUNT_BITS;
        if (total_ext == '0)
        begin
            eff_ext = TW'(1);
        end
        else if (total_ext > cap_ext)
        begin
            eff_ext = cap_ext;
        end
        else
        begin
            eff_ext = total_ext;
        end
        eff        = eff_ext[CW-1:0];
        done_below = (eff > done_reg);
        left       = done_below ? (eff - done_reg) : CW'(1);
    end

    // Next-state and result logic for one byte
    always_comb
    begin
        expect_hdr_next = expect_hdr_reg;
        run_next        = run_reg;
        remaining_next  = remaining_reg;
        bip_next        = bip_reg;
        pix_next        = pix_reg;
        done_next       = done_reg;
        key_next        = key_reg;
        ovr_next        = ovr_reg;

        last_idx  = cfg.four_bpp ? LAST_IDX_BGRA : LAST_IDX_BGR;
        hdr_count = {1'b0, data_byte[6:0]} + 8'd1;
        rep_pre   = 8'd1;
        rep       = 8'd1;
        done_sum  = done_reg;
        key_match = 1'b0;
        is_last   = 1'b0;
        res_valid = 1'b0;

        res.blue          = pix_reg[7:0];
        res.green         = pix_reg[15:8];
        res.red           = cfg.four_bpp ? pix_reg[23:16] : data_byte;
        res.alpha         = cfg.four_bpp ? data_byte : ALPHA_OPAQUE;
        res.repeat_res    = 8'd1;
        res.last_pixel    = 1'b0;
        res.overrun_error = ovr_reg;
        res.key_seen      = 1'b0;

        if (cfg.compressed && expect_hdr_reg)
        begin
            // Packet header: count clipped to the pixels still owed
            if (CW'(hdr_count) > left)
            begin
                remaining_next = left[7:0];
                ovr_next       = 1'b1;
            end
            else
            begin
                remaining_next = hdr_count;
            end
            run_next        = data_byte[7];
            expect_hdr_next = 1'b0;
            bip_next        = 2'd0;
        end
        else if (bip_reg < last_idx)
        begin
            // Collect a pixel byte
            case (bip_reg)
                2'd0:    pix_next[7:0]   = data_byte;
                2'd1:    pix_next[15:8]  = data_byte;
                2'd2:    pix_next[23:16] = data_byte;
                default: pix_next        = pix_reg;
            endcase
            bip_next = bip_reg + 2'd1;
        end
        else
        begin
            // Final byte of a pixel: emit a result
            res_valid = 1'b1;
            key_match = !cfg.four_bpp && cfg.use_key &&
                        ({ALPHA_OPAQUE, data_byte, pix_reg[15:0]} == cfg.color_key);
            if (key_match)
            begin
                res.alpha = ALPHA_CLEAR;
                key_next  = 1'b1;
            end
            bip_next = 2'd0;
            pix_next = '0;

            if (cfg.compressed)
            begin
                if (run_reg)
                begin
                    rep_pre         = (remaining_reg != 8'd0) ? remaining_reg : 8'd1;
                    remaining_next  = 8'd0;
                    expect_hdr_next = 1'b1;
                end
                else if (remaining_reg <= 8'd1)
                begin
                    remaining_next  = 8'd0;
                    expect_hdr_next = 1'b1;
                end
                else
                begin
                    remaining_next = remaining_reg - 8'd1;
                end
            end

            rep      = (CW'(rep_pre) > left) ? left[7:0] : rep_pre;
            done_sum = done_reg + CW'(rep);
            if (done_below)
            begin
                done_next = done_sum;
                is_last   = (done_sum >= eff);
            end
            else
            begin
                is_last = 1'b1;
            end

            res.repeat_res = rep;
            res.last_pixel = is_last;
            res.key_seen   = cfg.four_bpp ? cfg.use_key : (key_reg | key_match);

            // End of image: start over for the next one
            if (is_last)
            begin
                expect_hdr_next = 1'b1;
                run_next        = 1'b0;
                remaining_next  = 8'd0;
                bip_next        = 2'd0;
                pix_next        = '0;
                done_next       = '0;
                key_next        = 1'b0;
                ovr_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_hdr_reg <= 1'b1;
            run_reg        <= 1'b0;
            remaining_reg  <= 8'd0;
            bip_reg        <= 2'd0;
            pix_reg        <= '0;
            done_reg       <= '0;
            key_reg        <= 1'b0;
            ovr_reg        <= 1'b0;
        end
        else if (step)
        begin
            expect_hdr_reg <= expect_hdr_next;
            run_reg        <= run_next;
            remaining_reg  <= remaining_next;
            bip_reg        <= bip_next;
            pix_reg        <= pix_next;
            done_reg       <= done_next;
            key_reg        <= key_next;
            ovr_reg        <= ovr_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tgar_out_reg.sv
// Result register of the TGA run-length pixel decoder.
// Holds one decoded pixel until the downstream transfer completes.
// Depends on tgar_pkg (res_t).
`default_nettype none

module tgar_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire tgar_pkg::res_t load_res,
    input  wire logic           take,
    output logic                valid,
    output tgar_pkg::res_t      res
);
    import tgar_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // Valid: set on load, cleared when taken without a new load
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tgar_checker.sv
// Port-level checks for the TGA run-length pixel decoder, bound to the top level.
// Depends on tgar_pkg (port widths) and tga_rle_pixel_decoder_core.
`default_nettype none

module tgar_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [tgar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tlast,
    input wire logic [tgar_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import tgar_pkg::*;

    // Stalled result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Repeat count is one to one hundred twenty-eight
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:32] != 8'd0) && (m_axis_tdata[39:32] <= 8'd128))
        else $error("repeat count out of range");

    // Input only stalls behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with free output");

    // A fresh result follows a matching input transfer
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind tga_rle_pixel_decoder_core tgar_checker u_tgar_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
